[hw/rtl/swmm_pkg.sv]
// shared constants and types for the sliding window min/max unit
`default_nettype none

package swmm_pkg;

  // default sizes
  localparam int unsigned WINDOW_MAX_DEF   = 256;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  // width of the window size register
  localparam int unsigned CFG_W = 9;

  // per-cycle command broadcast to every cell of one queue
  typedef struct packed {
    logic pop;  // shift the queue one place toward the head
    logic ins;  // drop dominated tail entries and append the sample
    logic clr;  // end of stream: empty the queue
  } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/sliding_window_min_max_unit.sv]
// sliding window minimum and maximum over a stream of signed samples
//
// Samples arrive on the in_ channel (valid/ready) with a last_of_stream flag.
// Results leave on the out_ channel (valid/ready) as a min/max pair, one per
// sample once window_size samples have been seen since the last clear.
// window_size must be written through cfg_we_i/cfg_wdata_i only while the
// unit is idle; the unit itself does not enforce this. Zero acts as one,
// values above WINDOW_MAX act as WINDOW_MAX. Each sample is first taken as a
// request, then both cell rows drop dominated tail entries and append the
// sample. Every head entry that has aged out is shifted out of its row before
// the insert; both rows shift in the same cycle, so with a fixed window size
// each row shifts out at most one head per sample, and after a window shrink
// it may shift out more. The result is registered and shows on out_ the cycle
// after the insert. A held result does not block the next request; the insert
// cycle waits only while a head is shifted out or while the output register
// is still full and not being taken. Reset empties both queues, clears the
// sample count and sets the window to 1. A request with last_of_stream gives
// its result normally, but its insert empties both queues and clears the count.
`default_nettype none

module sliding_window_min_max_unit
  import swmm_pkg::*;
#(
  parameter int unsigned WINDOW_MAX   = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                    last_of_stream_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]      window_min_o,
  output logic [SAMPLE_WIDTH-1:0]      window_max_o
);

  localparam int unsigned POS_MOD = 2 * WINDOW_MAX;
  localparam int unsigned POS_W   = $clog2(POS_MOD);
  localparam int unsigned WIN_W   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned CW0     = (POS_W + 1 > WIN_W) ? POS_W + 1 : WIN_W;
  localparam int unsigned CW      = (CW0 > CFG_W) ? CW0 : CFG_W;

  typedef enum logic {
    S_IDLE,
    S_WORK
  } state_e;

  state_e                  state_q;
  logic [CFG_W-1:0]        win_cfg_q;
  logic [SAMPLE_WIDTH-1:0] key_q;
  logic                    last_q;
  logic [POS_W-1:0]        pos_q;
  logic                    full_q;
  logic                    out_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_min_q;
  logic [SAMPLE_WIDTH-1:0] out_max_q;

  logic [CW-1:0]           win_cw;
  logic [WIN_W-1:0]        win_eff;
  logic                    min_expired;
  logic                    max_expired;
  logic [SAMPLE_WIDTH-1:0] min_result;
  logic [SAMPLE_WIDTH-1:0] max_result;
  logic                    busy;
  logic                    do_ins;
  logic                    full_next;
  logic [POS_W-1:0]        pos_inc;
  cell_ctrl_t              min_ctrl;
  cell_ctrl_t              max_ctrl;

  // effective window size
  always_comb begin
    if (win_cfg_q == '0) begin
      win_cw = CW'(1);
    end else if (CW'(win_cfg_q) > CW'(WINDOW_MAX)) begin
      win_cw = CW'(WINDOW_MAX);
    end else begin
      win_cw = CW'(win_cfg_q);
    end
  end
  assign win_eff = WIN_W'(win_cw);

  // window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      win_cfg_q <= cfg_wdata_i;
    end
  end

  // pop aged-out heads first, insert once both heads are in the window
  assign busy      = min_expired || max_expired;
  assign do_ins    = (state_q == S_WORK) && !busy && (!out_valid_q || out_ready_i);
  assign full_next = full_q || (CW'({1'b0, pos_q} + (POS_W + 1)'(1)) >= win_cw);
  assign pos_inc   = (pos_q == POS_W'(POS_MOD - 1)) ? '0 : pos_q + POS_W'(1);

  always_comb begin
    min_ctrl.pop = (state_q == S_WORK) && min_expired;
    min_ctrl.ins = do_ins;
    min_ctrl.clr = do_ins && last_q;
    max_ctrl.pop = (state_q == S_WORK) && max_expired;
    max_ctrl.ins = do_ins;
    max_ctrl.clr = do_ins && last_q;
  end

  // minimum queue, increasing from head to tail
  swmm_queue #(
    .DEPTH  (WINDOW_MAX),
    .DW     (SAMPLE_WIDTH),
    .PW     (POS_W),
    .WW     (WIN_W),
    .IS_MIN (1'b1)
  ) u_min_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (min_ctrl),
    .key_i          (key_q),
    .pos_i          (pos_q),
    .win_i          (win_eff),
    .head_expired_o (min_expired),
    .head_result_o  (min_result)
  );

  // maximum queue, decreasing from head to tail
  swmm_queue #(
    .DEPTH  (WINDOW_MAX),
    .DW     (SAMPLE_WIDTH),
    .PW     (POS_W),
    .WW     (WIN_W),
    .IS_MIN (1'b0)
  ) u_max_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (max_ctrl),
    .key_i          (key_q),
    .pos_i          (pos_q),
    .win_i          (win_eff),
    .head_expired_o (max_expired),
    .head_result_o  (max_result)
  );

  // sequencer, stream counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      pos_q       <= '0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // result flag: set by an insert over a full window, cleared when taken
      if (do_ins && full_next) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            last_q  <= last_of_stream_i;
            state_q <= S_WORK;
          end
        end
        S_WORK: begin
          if (do_ins) begin
            pos_q   <= last_q ? '0 : pos_inc;
            full_q  <= last_q ? 1'b0 : full_next;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      key_q <= sample_i;
    end
    if (do_ins && full_next) begin
      out_min_q <= min_result;
      out_max_q <= max_result;
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign window_min_o = out_min_q;
  assign window_max_o = out_max_q;

endmodule

`default_nettype wire

[hw/rtl/swmm_cell.sv]
// one queue slot: holds a (value, position) entry and talks to its neighbors
`default_nettype none

module swmm_cell
  import swmm_pkg::*;
#(
  parameter int unsigned DW     = SAMPLE_WIDTH_DEF,
  parameter int unsigned PW     = 9,
  parameter bit          IS_MIN = 1'b1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cell_ctrl_t    ctrl_i,
  input  wire logic [DW-1:0] key_i,
  input  wire logic [PW-1:0] pos_i,
  input  wire logic          prev_keep_i,
  input  wire logic          nxt_valid_i,
  input  wire logic [DW-1:0] nxt_value_i,
  input  wire logic [PW-1:0] nxt_pos_i,
  output logic               valid_o,
  output logic [DW-1:0]      value_o,
  output logic [PW-1:0]      pos_o,
  output logic               keep_o
);

  logic          valid_q, valid_d;
  logic [DW-1:0] value_q, value_d;
  logic [PW-1:0] pos_q, pos_d;
  logic          dominated;

  // an entry that the new sample beats or ties can never win again
  always_comb begin
    if (IS_MIN) begin
      dominated = $signed(value_q) >= $signed(key_i);
    end else begin
      dominated = $signed(value_q) <= $signed(key_i);
    end
  end

  assign keep_o = valid_q && !dominated;

  // next entry: clear, shift from the neighbor, or insert at the first free slot
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    pos_d   = pos_q;
    if (ctrl_i.clr) begin
      valid_d = 1'b0;
    end else if (ctrl_i.pop) begin
      valid_d = nxt_valid_i;
      value_d = nxt_value_i;
      pos_d   = nxt_pos_i;
    end else if (ctrl_i.ins && !keep_o) begin
      if (prev_keep_i) begin
        valid_d = 1'b1;
        value_d = key_i;
        pos_d   = pos_i;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // entry payload
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign pos_o   = pos_q;

endmodule

`default_nettype wire

[hw/rtl/swmm_queue.sv]
// monotonic queue built from a row of cells, head at cell zero
`default_nettype none

module swmm_queue
  import swmm_pkg::*;
#(
  parameter int unsigned DEPTH  = WINDOW_MAX_DEF,
  parameter int unsigned DW     = SAMPLE_WIDTH_DEF,
  parameter int unsigned PW     = 9,
  parameter int unsigned WW     = 9,
  parameter bit          IS_MIN = 1'b1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire cell_ctrl_t    ctrl_i,
  input  wire logic [DW-1:0] key_i,
  input  wire logic [PW-1:0] pos_i,
  input  wire logic [WW-1:0] win_i,
  output logic               head_expired_o,
  output logic [DW-1:0]      head_result_o
);

  localparam int unsigned AW      = (PW + 1 > WW) ? PW + 1 : WW;
  localparam int unsigned POS_MOD = 2 * DEPTH;

  logic [DEPTH-1:0] valid;
  logic [DEPTH-1:0] keep;
  logic [DW-1:0]    value [DEPTH];
  logic [PW-1:0]    pos   [DEPTH];
  logic [PW:0]      diff;
  logic [PW:0]      age;

  // row of cells, each fed by its younger neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          prev_keep;
    logic          nxt_valid;
    logic [DW-1:0] nxt_value;
    logic [PW-1:0] nxt_pos;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_inner
      assign prev_keep = keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nxt_valid = 1'b0;
      assign nxt_value = value[i];
      assign nxt_pos   = pos[i];
    end else begin : g_body
      assign nxt_valid = valid[i+1];
      assign nxt_value = value[i+1];
      assign nxt_pos   = pos[i+1];
    end

    swmm_cell #(
      .DW     (DW),
      .PW     (PW),
      .IS_MIN (IS_MIN)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .key_i       (key_i),
      .pos_i       (pos_i),
      .prev_keep_i (prev_keep),
      .nxt_valid_i (nxt_valid),
      .nxt_value_i (nxt_value),
      .nxt_pos_i   (nxt_pos),
      .valid_o     (valid[i]),
      .value_o     (value[i]),
      .pos_o       (pos[i]),
      .keep_o      (keep[i])
    );
  end

  // age of the head entry, modulo twice the depth
  always_comb begin
    diff = {1'b0, pos_i} - {1'b0, pos[0]};
    if (pos_i >= pos[0]) begin
      age = diff;
    end else begin
      age = diff + (PW + 1)'(POS_MOD);
    end
  end

  assign head_expired_o = valid[0] && (AW'(age) >= AW'(win_i));

  // head after the pending insert: the old head if it survives, else the sample
  assign head_result_o = keep[0] ? value[0] : key_i;

endmodule

`default_nettype wire
